// File: hdl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned MaxPayloadW = 24;
  localparam int unsigned FragTotalW  = 25;
  localparam logic [MaxPayloadW-1:0] MaxPayloadReset = 24'd10485760;

  // Result kinds as seen downstream.
  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_PING  = 2'd1,
    EV_CLOSE = 2'd2,
    EV_ERROR = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic        unit_end;
    logic        byte_valid;
    event_kind_e event_kind;
    logic [7:0]  payload_byte;
  } wsd_result_t;

endpackage

// File: hdl/websocket_frame_deframer_top.sv
// A byte's result is registered in the output register, or the skid stage if stalled.
// Throughput: one received byte per cycle; s_axis_tready falls only while the skid
// stage holds a beat parked behind a stalled output register.
// Reset clears the parser to await a frame header, drops any open message and sets
// max_payload to 10 MiB; no clearing pass is needed, the block is ready at once.
`timescale 1ns / 1ps

module websocket_frame_deframer_top import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
  output logic [2:0]  m_axis_tuser,   // [1:0] event_kind, [2] byte_valid
  output logic        m_axis_tlast,   // unit_end
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [MaxPayloadW-1:0] max_payload_q;
  logic                   beat, res_valid, skid_ready;
  wsd_result_t            res, out_res;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {{(32-MaxPayloadW){1'b0}}, max_payload_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_payload_q <= pwdata[MaxPayloadW-1:0];
    end
  end

  assign s_axis_tready = skid_ready;
  assign beat          = s_axis_tvalid && skid_ready;

  wsd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_payload_i (max_payload_q),
    .beat_i        (beat),
    .rx_byte_i     (s_axis_tdata),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  wsd_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (skid_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tuser = {out_res.byte_valid, out_res.event_kind};
  assign m_axis_tlast = out_res.unit_end;

  // A close or error beat is the last one the block ever sends.
  a_final_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready &&
     (m_axis_tuser[1:0] == EV_CLOSE || m_axis_tuser[1:0] == EV_ERROR))
    |=> !m_axis_tvalid)
    else $error("result sent after close or error");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata == 8'h00))
    else $error("payload byte not cleared on a beat without data");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
    (m_axis_tuser[1:0] == EV_DATA || m_axis_tuser[1:0] == EV_PING))
    else $error("unit end on a close or error beat");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("skid stage full while output register is empty");

endmodule

// File: hdl/wsd_parser.sv
// Frame header parser, unmasker and fragment checker: one received byte per beat.
`timescale 1ns / 1ps

module wsd_parser import wsd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [MaxPayloadW-1:0] max_payload_i,
  input  logic                   beat_i,
  input  logic [7:0]             rx_byte_i,
  output logic                   res_valid_o,
  output wsd_result_t            res_o
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5,
    PH_ENDED = 3'd6
  } phase_e;

  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [MaxPayloadW-1:0] CtrlMaxLen = 24'd125;

  phase_e                 phase_q, phase_d;
  logic                   fin_q, fin_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   masked_q, masked_d;
  logic                   rsv_q, rsv_d;
  logic [MaxPayloadW-1:0] len_q, len_d;
  logic                   len_ovf_q, len_ovf_d;
  logic [MaxPayloadW-1:0] cnt_q, cnt_d;
  logic [31:0]            key_q, key_d;
  logic                   frag_open_q, frag_open_d;
  logic [FragTotalW-1:0]  frag_total_q, frag_total_d;
  logic                   doomed_q, doomed_d;

  logic                   hdr_now, end_now, end_has, fail_now;
  logic [7:0]             end_byte, plain, key_byte;
  logic [MaxPayloadW-1:0] hdr_len, cnt_inc;
  logic                   hdr_ovf, hdr_mask;
  logic [MaxPayloadW+1:0] frag_sum;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign plain    = rx_byte_i ^ key_byte;
  assign cnt_inc  = cnt_q + 1'b1;
  assign frag_sum = {1'b0, frag_total_q} + {2'b00, hdr_len};

  always_comb begin
    phase_d      = phase_q;
    fin_d        = fin_q;
    opcode_d     = opcode_q;
    masked_d     = masked_q;
    rsv_d        = rsv_q;
    len_d        = len_q;
    len_ovf_d    = len_ovf_q;
    cnt_d        = cnt_q;
    key_d        = key_q;
    frag_open_d  = frag_open_q;
    frag_total_d = frag_total_q;
    doomed_d     = doomed_q;
    hdr_now      = 1'b0;
    hdr_len      = {1'b0, len_q[15:0], rx_byte_i[6:0]};
    hdr_ovf      = 1'b0;
    hdr_mask     = masked_q;
    end_now      = 1'b0;
    end_has      = 1'b0;
    end_byte     = 8'h00;
    fail_now     = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '{unit_end: 1'b0, byte_valid: 1'b0, event_kind: EV_DATA,
                     payload_byte: 8'h00};

    if (beat_i) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d    = rx_byte_i[7];
          rsv_d    = rx_byte_i[6:4] != 3'b000;
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d  = rx_byte_i[7];
          cnt_d     = '0;
          len_ovf_d = 1'b0;
          if (rx_byte_i[6:0] == Len16Code) begin
            len_d   = '0;
            phase_d = PH_LEN16;
          end else if (rx_byte_i[6:0] == Len64Code) begin
            len_d   = '0;
            phase_d = PH_LEN64;
          end else begin
            hdr_now  = 1'b1;
            hdr_len  = {{(MaxPayloadW-7){1'b0}}, rx_byte_i[6:0]};
            hdr_mask = rx_byte_i[7];
          end
        end
        PH_LEN16, PH_LEN64: begin
          // Only 24 length bits are kept; anything shifted out past them is
          // already too large for any max_payload setting.
          len_d     = {len_q[MaxPayloadW-9:0], rx_byte_i};
          len_ovf_d = len_ovf_q | (len_q[MaxPayloadW-1:MaxPayloadW-8] != 8'h00);
          cnt_d     = cnt_inc;
          hdr_len   = len_d;
          hdr_ovf   = len_ovf_d;
          if (phase_q == PH_LEN16) hdr_now = cnt_q[2:0] == 3'd1;
          else                     hdr_now = cnt_q[2:0] == 3'd7;
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_inc;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_d = '0;
            if (len_q == '0) begin
              end_now = 1'b1;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          cnt_d = cnt_inc;
          if (cnt_inc == len_q) begin
            end_now  = 1'b1;
            end_has  = 1'b1;
            end_byte = plain;
          end else if (!doomed_q) begin
            if (opcode_q == OpCont || opcode_q == OpBinary) begin
              res_valid_o = 1'b1;
              res_o = '{unit_end: 1'b0, byte_valid: 1'b1, event_kind: EV_DATA,
                        payload_byte: plain};
            end else if (opcode_q == OpPing) begin
              res_valid_o = 1'b1;
              res_o = '{unit_end: 1'b0, byte_valid: 1'b1, event_kind: EV_PING,
                        payload_byte: plain};
            end
          end
        end
        default: begin
        end
      endcase

      if (hdr_now) begin
        len_d = hdr_len;
        if (hdr_ovf || !hdr_mask || rsv_q || hdr_len > max_payload_i ||
            (opcode_q[3] && (!fin_q || hdr_len > CtrlMaxLen))) begin
          fail_now = 1'b1;
        end else begin
          case (opcode_q)
            OpCont:                  doomed_d = !frag_open_q ||
                                                frag_sum > {2'b00, max_payload_i};
            OpBinary:                doomed_d = frag_open_q;
            OpClose, OpPing, OpPong: doomed_d = 1'b0;
            default:                 doomed_d = 1'b1;
          endcase
          phase_d = PH_MASK;
          cnt_d   = '0;
          key_d   = '0;
        end
      end

      if (end_now) begin
        if (doomed_q) begin
          fail_now = 1'b1;
        end else begin
          phase_d = PH_HDR0;
          case (opcode_q)
            OpCont, OpBinary: begin
              if (opcode_q == OpCont) begin
                frag_total_d = frag_total_q + {1'b0, len_q};
                if (fin_q) begin
                  frag_open_d  = 1'b0;
                  frag_total_d = '0;
                end
              end else if (!fin_q) begin
                frag_open_d  = 1'b1;
                frag_total_d = {1'b0, len_q};
              end
              if (end_has || fin_q) begin
                res_valid_o = 1'b1;
                res_o = '{unit_end: fin_q, byte_valid: end_has, event_kind: EV_DATA,
                          payload_byte: end_byte};
              end
            end
            OpClose: begin
              phase_d     = PH_ENDED;
              res_valid_o = 1'b1;
              res_o = '{unit_end: 1'b0, byte_valid: 1'b0, event_kind: EV_CLOSE,
                        payload_byte: 8'h00};
            end
            OpPing: begin
              res_valid_o = 1'b1;
              res_o = '{unit_end: 1'b1, byte_valid: end_has, event_kind: EV_PING,
                        payload_byte: end_byte};
            end
            default: begin
            end
          endcase
        end
      end

      if (fail_now) begin
        phase_d      = PH_ENDED;
        frag_open_d  = 1'b0;
        frag_total_d = '0;
        res_valid_o  = 1'b1;
        res_o = '{unit_end: 1'b0, byte_valid: 1'b0, event_kind: EV_ERROR,
                  payload_byte: 8'h00};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR0;
      fin_q        <= 1'b0;
      opcode_q     <= '0;
      masked_q     <= 1'b0;
      rsv_q        <= 1'b0;
      len_q        <= '0;
      len_ovf_q    <= 1'b0;
      cnt_q        <= '0;
      key_q        <= '0;
      frag_open_q  <= 1'b0;
      frag_total_q <= '0;
      doomed_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      fin_q        <= fin_d;
      opcode_q     <= opcode_d;
      masked_q     <= masked_d;
      rsv_q        <= rsv_d;
      len_q        <= len_d;
      len_ovf_q    <= len_ovf_d;
      cnt_q        <= cnt_d;
      key_q        <= key_d;
      frag_open_q  <= frag_open_d;
      frag_total_q <= frag_total_d;
      doomed_q     <= doomed_d;
    end
  end

endmodule

// File: hdl/wsd_out_skid.sv
// Result register with a skid stage so the input side keeps flowing under backpressure.
`timescale 1ns / 1ps

module wsd_out_skid import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  wsd_result_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output wsd_result_t out_data_o
);

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  wsd_result_t out_q, out_d;
  wsd_result_t skid_q, skid_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && !out_ready_i) begin
      // Output is stalled: park a new beat in the skid stage.
      if (in_valid_i && !skid_valid_q) begin
        skid_valid_d = 1'b1;
        skid_d       = in_data_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = in_valid_i;
      out_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// File: verif/websocket_frame_deframer_top_tb.sv
// Self-checking testbench for the WebSocket frame deframer top level.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;
  import wsd_pkg::*;

  localparam logic [2:0] ADDR_MAX_PAYLOAD = 3'd0;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam int unsigned CTRL_MAX_LEN = 125;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 4;
  localparam int END_CYCLES       = 8;
  localparam int MAX_REPORTS      = 200;
  localparam int TIMEOUT_NS       = 400000;

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_LEN16, ST_LEN64, ST_MASK, ST_DATA, ST_ENDED
  } parse_state_e;

  typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_e;

  // Ways in which the connection is finally brought down.
  typedef enum int {
    END_CLOSE, END_UNMASKED, END_RESERVED, END_OVERSIZE, END_LEN_MSB,
    END_CTRL_FRAGMENTED, END_CTRL_LONG, END_BAD_OPCODE, END_ORPHAN_CONT,
    END_MSG_OVERSIZE, END_BIN_IN_MSG, END_DOOMED_EMPTY
  } ending_e;

  class deframer_scoreboard;
    logic [23:0]  max_len;
    parse_state_e state;
    logic         fin;
    logic [3:0]   opcode;
    logic         masked;
    logic         rsv;
    logic [63:0]  frame_len;
    logic [63:0]  taken;
    logic [31:0]  mask_word;
    logic         msg_open;
    logic [24:0]  msg_total;
    logic         doomed;
    wsd_result_t  expected_events[$];
    int           errors;

    function new();
      max_len   = MaxPayloadReset;
      state     = ST_HDR0;
      fin       = 1'b0;
      opcode    = 4'h0;
      masked    = 1'b0;
      rsv       = 1'b0;
      frame_len = '0;
      taken     = '0;
      mask_word = '0;
      msg_open  = 1'b0;
      msg_total = '0;
      doomed    = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void add_event(event_kind_e kind, logic [7:0] b, logic valid, logic last);
      wsd_result_t r;
      r.event_kind   = kind;
      r.payload_byte = valid ? b : 8'd0;
      r.byte_valid   = valid;
      r.unit_end     = last;
      expected_events = {expected_events, r};
    endfunction

    function void protocol_error();
      state     = ST_ENDED;
      msg_open  = 1'b0;
      msg_total = '0;
      add_event(EV_ERROR, 8'd0, 1'b0, 1'b0);
    endfunction

    function void finish_header();
      if (frame_len[63] || !masked || rsv || frame_len > {40'd0, max_len} ||
          (opcode[3] && (!fin || frame_len > CTRL_MAX_LEN))) begin
        protocol_error();
        return;
      end
      case (opcode)
        OP_CONT: doomed = !msg_open || ({39'd0, msg_total} + frame_len > {40'd0, max_len});
        OP_BIN: doomed = msg_open;
        OP_CLOSE, OP_PING, OP_PONG: doomed = 1'b0;
        default: doomed = 1'b1;
      endcase
      state     = ST_MASK;
      taken     = '0;
      mask_word = '0;
    endfunction

    function void close_frame(logic has, logic [7:0] b);
      if (doomed) begin
        protocol_error();
        return;
      end
      state = ST_HDR0;
      case (opcode)
        OP_CONT: begin
          msg_total = msg_total + frame_len[24:0];
          if (fin) begin
            msg_open  = 1'b0;
            msg_total = '0;
          end
          if (has || fin) add_event(EV_DATA, b, has, fin);
        end
        OP_BIN: begin
          if (!fin) begin
            msg_open  = 1'b1;
            msg_total = frame_len[24:0];
          end
          if (has || fin) add_event(EV_DATA, b, has, fin);
        end
        OP_CLOSE: begin
          state = ST_ENDED;
          add_event(EV_CLOSE, 8'd0, 1'b0, 1'b0);
        end
        OP_PING: add_event(EV_PING, b, has, 1'b1);
        default: ;
      endcase
    endfunction

    // Advances the parser by one received byte and queues whatever it produces.
    function void take_byte(logic [7:0] b);
      logic [1:0] lane;
      logic [7:0] plain;
      case (state)
        ST_HDR0: begin
          fin    = b[7];
          rsv    = |b[6:4];
          opcode = b[3:0];
          state  = ST_HDR1;
        end
        ST_HDR1: begin
          masked    = b[7];
          frame_len = {57'd0, b[6:0]};
          taken     = '0;
          if (b[6:0] == LEN_EXT16) begin
            frame_len = '0;
            state     = ST_LEN16;
          end else if (b[6:0] == LEN_EXT64) begin
            frame_len = '0;
            state     = ST_LEN64;
          end else begin
            finish_header();
          end
        end
        ST_LEN16, ST_LEN64: begin
          frame_len = {frame_len[55:0], b};
          taken++;
          if (taken == ((state == ST_LEN16) ? 64'd2 : 64'd8)) finish_header();
        end
        ST_MASK: begin
          mask_word = {mask_word[23:0], b};
          taken++;
          if (taken == 64'd4) begin
            taken = '0;
            if (frame_len == 64'd0) close_frame(1'b0, 8'd0);
            else state = ST_DATA;
          end
        end
        ST_DATA: begin
          lane  = taken[1:0];
          plain = b ^ mask_word[8 * (3 - int'(lane)) +: 8];
          taken++;
          if (taken >= frame_len) begin
            close_frame(1'b1, plain);
          end else if (!doomed) begin
            if (opcode == OP_CONT || opcode == OP_BIN) add_event(EV_DATA, plain, 1'b1, 1'b0);
            else if (opcode == OP_PING) add_event(EV_PING, plain, 1'b1, 1'b0);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(wsd_result_t got);
      wsd_result_t want;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        return;
      end
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind)
        report("event_kind", want.event_kind, got.event_kind);
      if (got.payload_byte !== want.payload_byte)
        report("payload_byte", want.payload_byte, got.payload_byte);
      if (got.byte_valid !== want.byte_valid)
        report("byte_valid", want.byte_valid, got.byte_valid);
      if (got.unit_end !== want.unit_end)
        report("unit_end", want.unit_end, got.unit_end);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] payload_byte
  logic [2:0]  m_axis_tuser;   // [1:0] event_kind, [2] byte_valid
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  deframer_scoreboard sb = new();
  logic idle_on     = 1'b1;
  int   hold_asked  = 0;
  int   hold_done   = 0;
  int   sent_count  = 0;

  websocket_frame_deframer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Results are checked before the byte accepted at the same edge is noted, so the
  // order of the two within a step never matters.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(wsd_result_t'({m_axis_tlast, m_axis_tuser, m_axis_tdata}));
      if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata);
    end
  end

  initial begin : sink
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done++;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL websocket_frame_deframer_top");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic mask, input len_enc_e enc, input logic [63:0] len,
                            input int unsigned nbytes);
    logic [31:0] mask_word;
    mask_word = $urandom;
    send_byte({fin, rsv, op});
    case (enc)
      ENC_SHORT: send_byte({mask, len[6:0]});
      ENC_16: begin
        send_byte({mask, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (mask) for (int i = 3; i >= 0; i--) send_byte(mask_word[8 * i +: 8]);
    repeat (nbytes) send_byte(8'($urandom));
  endtask

  function automatic len_enc_e pick_enc(int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (len > CTRL_MAX_LEN) return (r == 0) ? ENC_64 : ENC_16;
    if (r == 0) return ENC_16;
    if (r == 1) return ENC_64;
    return ENC_SHORT;
  endfunction

  function automatic int unsigned pick_len(int unsigned room);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 15);
    if (r < 10) len = $urandom_range(0, 8);
    else if (r < 15) len = $urandom_range(9, 40);
    else len = $urandom_range(120, 300);
    return (len > room) ? room : len;
  endfunction

  function automatic logic [3:0] unsupported_opcode();
    logic [3:0] op;
    do op = 4'($urandom); while (op inside {OP_CONT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG});
    return op;
  endfunction

  task automatic random_control(input bit empty_only);
    logic [3:0]  op;
    int unsigned cap;
    int unsigned len;
    op  = $urandom_range(0, 1) ? OP_PING : OP_PONG;
    cap = (sb.max_len < CTRL_MAX_LEN) ? int'(sb.max_len) : CTRL_MAX_LEN;
    len = ($urandom_range(0, 9) == 0) ? cap : $urandom_range(0, 12);
    if (len > cap) len = cap;
    if (empty_only) len = 0;
    send_frame(1'b1, 3'b000, op, 1'b1, pick_enc(len), len, len);
  endtask

  // A whole binary message, maybe split with control frames between, or a control frame.
  task automatic random_message(input bit empty_only);
    int unsigned nfrag;
    int unsigned room;
    int unsigned len;
    if ($urandom_range(0, 9) < 6) begin
      nfrag = $urandom_range(1, 3);
      room  = sb.max_len;
      for (int i = 0; i < nfrag; i++) begin
        len  = empty_only ? 0 : pick_len(room);
        room = room - len;
        send_frame(i == nfrag - 1, 3'b000, (i == 0) ? OP_BIN : OP_CONT, 1'b1, pick_enc(len),
                   len, len);
        if (i != nfrag - 1 && $urandom_range(0, 3) == 0) random_control(empty_only);
      end
    end else begin
      random_control(empty_only);
    end
  endtask

  task automatic random_traffic(input int budget, input bit empty_only);
    int start;
    start = sent_count;
    while (sent_count - start < budget) random_message(empty_only);
  endtask

  task automatic end_connection();
    ending_e     how;
    int unsigned m;
    int unsigned len;
    how = ending_e'($urandom_range(0, int'(END_DOOMED_EMPTY)));
    m   = sb.max_len;
    case (how)
      END_CLOSE: begin
        len = $urandom_range(0, 4);
        send_frame(1'b1, 3'b000, OP_CLOSE, 1'b1, ENC_SHORT, len, len);
      end
      END_UNMASKED: send_frame(1'b1, 3'b000, OP_BIN, 1'b0, ENC_SHORT, 2, 2);
      END_RESERVED:
        send_frame(1'b1, 3'($urandom_range(1, 7)), OP_BIN, 1'b1, ENC_SHORT, 2, 2);
      END_OVERSIZE: send_frame(1'b1, 3'b000, OP_BIN, 1'b1, ENC_16, m + 1, 0);
      END_LEN_MSB:
        send_frame(1'b1, 3'b000, OP_BIN, 1'b1, ENC_64, {1'b1, 31'($urandom), $urandom}, 0);
      END_CTRL_FRAGMENTED: send_frame(1'b0, 3'b000, OP_PING, 1'b1, ENC_SHORT, 0, 0);
      END_CTRL_LONG: send_frame(1'b1, 3'b000, OP_PING, 1'b1, ENC_16, CTRL_MAX_LEN + 1, 0);
      END_BAD_OPCODE: begin
        len = $urandom_range(1, 4);
        send_frame(1'b1, 3'b000, unsupported_opcode(), 1'b1, ENC_SHORT, len, len);
      end
      END_ORPHAN_CONT: send_frame(1'($urandom), 3'b000, OP_CONT, 1'b1, ENC_SHORT, 2, 2);
      END_MSG_OVERSIZE: begin
        // The continuation alone fits, but the reassembled message does not.
        send_frame(1'b0, 3'b000, OP_BIN, 1'b1, ENC_SHORT, 1, 1);
        send_frame(1'b1, 3'b000, OP_CONT, 1'b1, ENC_SHORT, m, m);
      end
      END_BIN_IN_MSG: begin
        send_frame(1'b0, 3'b000, OP_BIN, 1'b1, ENC_SHORT, 1, 1);
        send_frame(1'b1, 3'b000, OP_BIN, 1'b1, ENC_SHORT, 1, 1);
      end
      default: send_frame(1'b1, 3'b000, unsupported_opcode(), 1'b1, ENC_SHORT, 0, 0);
    endcase
  endtask

  // The first edge lets the monitor note the last byte before the queue is inspected.
  task automatic settle(input int cycles);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic read_max_payload(input logic [23:0] want);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= ADDR_MAX_PAYLOAD;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[23:0] !== want) begin
      sb.errors++;
      $display("%0t: max_payload read mismatch, expected %0h, actual %0h", $time, want,
               prdata[23:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_max_payload(input logic [23:0] value);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= ADDR_MAX_PAYLOAD;
    pwdata <= {8'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.max_len = value;
    @(posedge clk_i);
    read_max_payload(value);
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = ADDR_MAX_PAYLOAD;
    pwdata        = 32'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_max_payload(MaxPayloadReset);

    // Empty non-final start of a message, its final continuation, an empty ping and a pong.
    send_frame(1'b0, 3'b000, OP_BIN, 1'b1, ENC_SHORT, 0, 0);
    send_frame(1'b1, 3'b000, OP_CONT, 1'b1, ENC_SHORT, 1, 1);
    send_frame(1'b1, 3'b000, OP_PING, 1'b1, ENC_SHORT, 0, 0);
    send_frame(1'b1, 3'b000, OP_PONG, 1'b1, ENC_SHORT, 1, 1);

    // A long frame arrives while the results are held off, so the input must stall.
    hold_asked <= hold_asked + 1;
    send_frame(1'b1, 3'b000, OP_BIN, 1'b1, ENC_16, 200, 200);
    random_traffic(340, 1'b0);

    settle(SETTLE_CYCLES);
    write_max_payload(24'hFFFFFF);
    random_traffic(320, 1'b0);

    settle(SETTLE_CYCLES);
    write_max_payload(24'd0);
    random_traffic(60, 1'b1);

    settle(SETTLE_CYCLES);
    write_max_payload(24'($urandom_range(1, 300)));
    idle_on <= 1'b0;
    random_traffic(250, 1'b0);

    settle(SETTLE_CYCLES);
    write_max_payload(24'($urandom_range(8, 60)));
    random_traffic(150, 1'b0);
    end_connection();
    // Once the connection is down every further byte must be swallowed.
    repeat (16) send_byte(8'($urandom));

    settle(END_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS websocket_frame_deframer_top");
    end else begin
      $display("FAIL websocket_frame_deframer_top");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/wsd_out_skid.sv
hdl/websocket_frame_deframer_top.sv
verif/websocket_frame_deframer_top_tb.sv
